FILE: hdl/occlusion_span_clip_list_top_macros.svh
// Assertion shorthands used by the checked module.
`ifndef OCCLUSION_SPAN_CLIP_LIST_TOP_MACROS_SVH
`define OCCLUSION_SPAN_CLIP_LIST_TOP_MACROS_SVH

// Plain property, sampled on clk, off during reset.
`define OSCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define OSCL_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define OSCL_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/oscl_pkg.sv
package oscl_pkg;

  localparam int MAX_SPANS_DEF = 32;
  localparam int COL_W         = 10;
  localparam int VW_W          = 11;

  localparam logic [VW_W-1:0]   VW_RESET = 11'd320;
  localparam logic signed [15:0] LEFT_LO  = -16'sd32767;
  localparam logic signed [15:0] LEFT_HI  = -16'sd1;
  localparam logic signed [15:0] RIGHT_HI = 16'sd32767;
  localparam logic signed [16:0] NO_END   = -17'sd32768;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_SOLID = 2'd1,
    REQ_PASS  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALIGN
  } state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [COL_W-1:0] first;
    logic [COL_W-1:0] last;
  } req_t;

  typedef struct packed {
    logic [COL_W-1:0] span_first;
    logic [COL_W-1:0] span_last;
    logic             has_span;
    logic             last_of_run;
    logic             overflow;
  } res_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } span_t;

  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctl_t;

  function automatic logic signed [16:0] sx(input logic signed [15:0] v);
    return {v[15], v};
  endfunction

endpackage

FILE: hdl/occlusion_span_clip_list_top.sv
// channel   | handshake            | payload
// request   | start / busy         | req (req_type, first, last)
// result    | res_valid (strobe)   | res (span_first, span_last, has_span, last_of_run, overflow)
// config    | cfg_we               | cfg_wdata (view_width)
//
// A pass request shifts the cell chain once per list slot, then makes one alignment check. A
// solid request that merges into the left sentinel, or whose inserted span is still held back
// at the end of the walk, keeps shifting in the alignment state until the left sentinel is
// back at the head. Clear, unused and empty requests do not walk the chain.
// Reset (synchronous) loads the two sentinels with a view width of 320.
// Results come one per cycle and cannot be stalled; last_of_run closes each run.
module occlusion_span_clip_list_top #(
  parameter int MAX_SPANS = oscl_pkg::MAX_SPANS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  oscl_pkg::req_t               req,
  input  logic                         cfg_we,
  input  logic [oscl_pkg::VW_W-1:0]    cfg_wdata,
  output logic                         res_valid,
  output oscl_pkg::res_t               res
);
  import oscl_pkg::*;

  logic [VW_W-1:0] view_width;
  logic [VW_W-1:0] vw_init;
  chain_ctl_t      ctl;
  span_t           push;
  span_t           cells [MAX_SPANS];

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width <= VW_RESET;
    end else if (cfg_we) begin
      view_width <= cfg_wdata;
    end
  end

  assign vw_init = rst ? VW_RESET : view_width;

  for (genvar i = 0; i < MAX_SPANS; i++) begin : g_cell
    span_t init, nxt;
    if (i == 0) begin : g_left
      assign init = '{valid: 1'b1, lo: LEFT_LO, hi: LEFT_HI};
    end else if (i == 1) begin : g_right
      assign init = '{valid: 1'b1, lo: 16'(vw_init), hi: RIGHT_HI};
    end else begin : g_free
      assign init = '0;
    end
    if (i == MAX_SPANS - 1) begin : g_tail
      assign nxt = push;
    end else begin : g_body
      assign nxt = cells[i+1];
    end
    oscl_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .init (init),
      .nxt  (nxt),
      .data (cells[i])
    );
  end

  oscl_ctrl #(
    .MAX_SPANS (MAX_SPANS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .head      (cells[0]),
    .ctl       (ctl),
    .push      (push),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

FILE: hdl/oscl_cell.sv
module oscl_cell (
  input  logic                clk,
  input  logic                rst,
  input  oscl_pkg::chain_ctl_t ctl,
  input  oscl_pkg::span_t     init,
  input  oscl_pkg::span_t     nxt,
  output oscl_pkg::span_t     data
);
  import oscl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.load) begin
      data <= init;
    end else if (ctl.shift) begin
      data <= nxt;
    end
  end

endmodule

FILE: hdl/oscl_ctrl.sv
module oscl_ctrl #(
  parameter int MAX_SPANS = oscl_pkg::MAX_SPANS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  oscl_pkg::req_t       req,
  input  oscl_pkg::span_t      head,
  output oscl_pkg::chain_ctl_t ctl,
  output oscl_pkg::span_t      push,
  output logic                 res_valid,
  output oscl_pkg::res_t       res
);
  import oscl_pkg::*;
  `include "occlusion_span_clip_list_top_macros.svh"

  localparam int IW = $clog2(MAX_SPANS);
  localparam int CW = $clog2(MAX_SPANS + 1);

  state_e             state, state_next;
  logic [IW-1:0]      idx, idx_next;
  logic [CW-1:0]      count, count_next;
  logic               store, store_next;
  logic signed [16:0] f, f_next, l, l_next;
  logic               in_g, in_g_next, done_n, done_n_next;
  logic signed [16:0] acc_lo, acc_lo_next, acc_hi, acc_hi_next;
  span_t              carry, carry_next;
  logic signed [16:0] prev_end, prev_end_next;
  logic               frag_v, frag_v_next;
  logic [COL_W-1:0]   frag_lo, frag_lo_next, frag_hi, frag_hi_next;
  logic               fin, fin_next, ovf, ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= CW'(2);
      carry  <= '0;
      fin    <= 1'b0;
      frag_v <= 1'b0;
      ovf    <= 1'b0;
      in_g   <= 1'b0;
      done_n <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      carry  <= carry_next;
      fin    <= fin_next;
      frag_v <= frag_v_next;
      ovf    <= ovf_next;
      in_g   <= in_g_next;
      done_n <= done_n_next;
    end
    idx      <= idx_next;
    store    <= store_next;
    f        <= f_next;
    l        <= l_next;
    acc_lo   <= acc_lo_next;
    acc_hi   <= acc_hi_next;
    prev_end <= prev_end_next;
    frag_lo  <= frag_lo_next;
    frag_hi  <= frag_hi_next;
  end

  always_comb begin
    logic signed [16:0] es, ee, glo, ghi;
    logic               touch, nf;
    span_t              it0, it1, nspan, aspan;

    es = sx(head.lo);
    ee = sx(head.hi);
    it0 = '0;
    it1 = '0;
    nspan = '{valid: 1'b1, lo: f[15:0], hi: l[15:0]};
    aspan = '0;
    glo = (f > prev_end + 17'sd1) ? f : prev_end + 17'sd1;
    ghi = (l < es - 17'sd1) ? l : es - 17'sd1;
    nf = head.valid && (glo <= ghi);
    touch = (es <= l + 17'sd1) && (ee >= f - 17'sd1);

    state_next    = state;
    idx_next      = idx;
    count_next    = count;
    store_next    = store;
    f_next        = f;
    l_next        = l;
    in_g_next     = in_g;
    done_n_next   = done_n;
    acc_lo_next   = acc_lo;
    acc_hi_next   = acc_hi;
    carry_next    = carry;
    prev_end_next = prev_end;
    frag_v_next   = frag_v;
    frag_lo_next  = frag_lo;
    frag_hi_next  = frag_hi;
    fin_next      = 1'b0;
    ovf_next      = ovf;
    ctl           = '0;
    push          = '0;
    busy          = (state != ST_IDLE) || fin;
    res_valid     = 1'b0;
    res           = '0;

    if (fin) begin
      res_valid       = 1'b1;
      res.span_first  = frag_v ? frag_lo : '0;
      res.span_last   = frag_v ? frag_hi : '0;
      res.has_span    = frag_v;
      res.last_of_run = 1'b1;
      res.overflow    = ovf;
    end

    unique case (state)
      ST_IDLE: begin
        if (start && !busy) begin
          frag_v_next = 1'b0;
          ovf_next    = 1'b0;
          if ((req.req_type == REQ_SOLID || req.req_type == REQ_PASS) &&
              (req.last >= req.first)) begin
            state_next    = ST_WALK;
            idx_next      = '0;
            store_next    = (req.req_type == REQ_SOLID);
            f_next        = 17'(req.first);
            l_next        = 17'(req.last);
            in_g_next     = 1'b0;
            done_n_next   = 1'b0;
            prev_end_next = NO_END;
          end else begin
            fin_next = 1'b1;
            if (req.req_type == REQ_CLEAR) begin
              ctl.load   = 1'b1;
              count_next = CW'(2);
            end
          end
        end
      end
      ST_WALK: begin
        ctl.shift = 1'b1;
        idx_next  = idx + IW'(1);
        if (head.valid) begin
          prev_end_next = ee;
        end
        if (nf) begin
          if (frag_v) begin
            res_valid      = 1'b1;
            res.span_first = frag_lo;
            res.span_last  = frag_hi;
            res.has_span   = 1'b1;
            res.overflow   = ovf;
          end
          frag_v_next  = 1'b1;
          frag_lo_next = glo[COL_W-1:0];
          frag_hi_next = ghi[COL_W-1:0];
        end

        if (!head.valid) begin
          it0 = '0;
        end else if (!store || done_n) begin
          it0 = head;
        end else if (touch) begin
          if (!in_g) begin
            in_g_next   = 1'b1;
            acc_lo_next = (f < es) ? f : es;
            acc_hi_next = (l > ee) ? l : ee;
          end else begin
            acc_hi_next = (acc_hi > ee) ? acc_hi : ee;
            count_next  = count - CW'(1);
          end
        end else if (es > l + 17'sd1) begin
          done_n_next = 1'b1;
          if (in_g) begin
            in_g_next = 1'b0;
            it0 = '{valid: 1'b1, lo: acc_lo[15:0], hi: acc_hi[15:0]};
            it1 = head;
          end else if (count < CW'(MAX_SPANS)) begin
            count_next = count + CW'(1);
            it0 = nspan;
            it1 = head;
          end else begin
            ovf_next = 1'b1;
            it0 = head;
          end
        end else begin
          it0 = head;
        end

        if (idx == IW'(MAX_SPANS - 1)) begin
          state_next = ST_ALIGN;
          fin_next   = 1'b1;
          if (in_g_next) begin
            in_g_next = 1'b0;
            aspan = '{valid: 1'b1, lo: acc_lo_next[15:0], hi: acc_hi_next[15:0]};
            if (it0.valid) begin
              it1 = aspan;
            end else begin
              it0 = aspan;
            end
          end
        end

        if (carry.valid) begin
          push       = carry;
          carry_next = it0;
        end else begin
          push       = it0;
          carry_next = it1;
        end
      end
      ST_ALIGN: begin
        if (!carry.valid && head.valid && head.lo == LEFT_LO) begin
          state_next = ST_IDLE;
        end else begin
          ctl.shift = 1'b1;
          if (carry.valid) begin
            push       = carry;
            carry_next = head;
          end else begin
            push = head;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `OSCL_IMPLY(a_idle_no_carry, state == ST_IDLE, !carry.valid, "carry left over in idle")
  `OSCL_ASSERT(a_count_max, count <= CW'(MAX_SPANS), "span count above capacity")
  `OSCL_IMPLY(a_res_busy, res_valid, busy, "result outside a request")
  `OSCL_IMPLY_NEXT(a_accept_busy, start && !busy, busy, "accepted request not busy")

endmodule

FILE: tb/occlusion_span_clip_list_checker.sv
`timescale 1ns / 1ps

module occlusion_span_clip_list_checker
  import oscl_pkg::*;
#(
  parameter int MAX_SPANS = MAX_SPANS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  req_t                req,
  input  logic                cfg_we,
  input  logic [VW_W-1:0]     cfg_wdata,
  input  logic                res_valid,
  input  res_t                res,
  output int                  pending,
  output int                  errors
);

  logic signed [15:0] occ_lo [MAX_SPANS];
  logic signed [15:0] occ_hi [MAX_SPANS];
  int                 occ_count;
  logic [VW_W-1:0]    view_width;
  res_t               expected_fragments [$];
  res_t               run [$];

  assign pending = expected_fragments.size();

  task automatic report(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic reset_list();
    for (int i = 0; i < MAX_SPANS; i++) begin
      occ_lo[i] = '0;
      occ_hi[i] = '0;
    end
    occ_lo[0] = LEFT_LO;
    occ_hi[0] = LEFT_HI;
    occ_lo[1] = 16'(view_width);
    occ_hi[1] = RIGHT_HI;
    occ_count = 2;
  endtask

  task automatic add_fragment(input int a, input int b);
    res_t r;
    if (a > b || run.size() >= MAX_SPANS) return;
    r = '0;
    r.span_first = a[COL_W-1:0];
    r.span_last  = b[COL_W-1:0];
    r.has_span   = 1'b1;
    run.push_back(r);
  endtask

  // drop entries s+1 .. nx, now covered by entry s
  task automatic absorb(input int s, input int nx);
    int tail;
    if (nx <= s) return;
    tail = occ_count - nx - 1;
    for (int i = 0; i < tail; i++) begin
      occ_lo[s + 1 + i] = occ_lo[nx + 1 + i];
      occ_hi[s + 1 + i] = occ_hi[nx + 1 + i];
    end
    occ_count -= nx - s;
  endtask

  task automatic clip_span_list(input int f, input int l, input bit store, output bit ovf);
    int s;
    int nx;
    s = 0;
    ovf = 1'b0;
    while (s < occ_count - 1 && int'(occ_hi[s]) < f - 1) s++;
    if (f < int'(occ_lo[s])) begin
      if (l < int'(occ_lo[s]) - 1) begin
        add_fragment(f, l);
        if (store) begin
          if (occ_count >= MAX_SPANS) begin
            ovf = 1'b1;
          end else begin
            for (int i = occ_count; i > s; i--) begin
              occ_lo[i] = occ_lo[i - 1];
              occ_hi[i] = occ_hi[i - 1];
            end
            occ_lo[s] = 16'(f);
            occ_hi[s] = 16'(l);
            occ_count++;
          end
        end
        return;
      end
      add_fragment(f, int'(occ_lo[s]) - 1);
      if (store) occ_lo[s] = 16'(f);
    end
    if (l <= int'(occ_hi[s])) return;
    nx = s;
    while (nx + 1 < occ_count && l >= int'(occ_lo[nx + 1]) - 1) begin
      add_fragment(int'(occ_hi[nx]) + 1, int'(occ_lo[nx + 1]) - 1);
      nx++;
      if (l <= int'(occ_hi[nx])) begin
        if (store) begin
          occ_hi[s] = occ_hi[nx];
          absorb(s, nx);
        end
        return;
      end
    end
    add_fragment(int'(occ_hi[nx]) + 1, l);
    if (store) begin
      occ_hi[s] = 16'(l);
      absorb(s, nx);
    end
  endtask

  task automatic predict(input req_t r);
    bit   ovf;
    res_t t;
    run.delete();
    ovf = 1'b0;
    if (r.req_type == REQ_CLEAR) begin
      reset_list();
    end else if ((r.req_type == REQ_SOLID || r.req_type == REQ_PASS) && r.last >= r.first) begin
      clip_span_list(int'(r.first), int'(r.last), r.req_type == REQ_SOLID, ovf);
    end
    if (run.size() == 0) run.push_back('0);
    foreach (run[i]) run[i].overflow = ovf;
    run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) expected_fragments.push_back(run[i]);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      errors = 0;
      view_width = VW_RESET;
      reset_list();
      expected_fragments.delete();
    end else begin
      if (res_valid) begin
        if (expected_fragments.size() == 0) begin
          report($sformatf("unexpected result %p", res));
        end else begin
          want = expected_fragments.pop_front();
          if (res.span_first !== want.span_first)
            report($sformatf("span_first %0d, want %0d", res.span_first, want.span_first));
          if (res.span_last !== want.span_last)
            report($sformatf("span_last %0d, want %0d", res.span_last, want.span_last));
          if (res.has_span !== want.has_span)
            report($sformatf("has_span %b, want %b", res.has_span, want.has_span));
          if (res.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %b, want %b", res.last_of_run, want.last_of_run));
          if (res.overflow !== want.overflow)
            report($sformatf("overflow %b, want %b", res.overflow, want.overflow));
        end
      end
      if (start && !busy) predict(req);
      if (cfg_we) view_width = cfg_wdata;
    end
  end

endmodule

FILE: tb/occlusion_span_clip_list_top_tb.sv
`timescale 1ns / 1ps

module occlusion_span_clip_list_top_tb;
  import oscl_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  req_t            req = '0;
  logic            cfg_we = 1'b0;
  logic [VW_W-1:0] cfg_wdata = '0;
  logic            res_valid;
  res_t            res;
  int              pending;
  int              errors;
  int              quiet_cycles = 0;
  int              vw = 320;

  always #5 clk = ~clk;

  occlusion_span_clip_list_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  occlusion_span_clip_list_checker chk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res),
    .pending   (pending),
    .errors    (errors)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || res_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("occlusion_span_clip_list_top test failed");
        $finish;
      end
    end
  end

  task automatic send(input req_e t, input int f, input int l);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req.req_type <= t;
    req.first <= f[COL_W-1:0];
    req.last <= l[COL_W-1:0];
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic set_view_width(input int w);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= w[VW_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    vw = w;
    send(REQ_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  // single-column spans with one-column gaps until the list is full, then one more
  task automatic fill_list();
    send(REQ_CLEAR, 0, 0);
    for (int k = 1; k <= 31; k++) send(REQ_SOLID, 2 * k, 2 * k);
    send(REQ_PASS, 0, 1023);
    send(REQ_SOLID, 3, 3);
    send(REQ_SOLID, 90, 95);
  endtask

  task automatic random_item();
    int pick;
    int f;
    int l;
    int hi;
    pick = $urandom_range(0, 99);
    hi = (vw > 1023) ? 1023 : vw;
    f = $urandom_range(0, hi);
    if ($urandom_range(0, 9) == 0) f = $urandom_range(0, 1023);
    l = f + $urandom_range(0, 15);
    if ($urandom_range(0, 7) == 0) l = $urandom_range(f, 1023);
    if (l > 1023) l = 1023;
    if (pick < 4) send(REQ_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023));
    else if (pick < 7) send(REQ_NONE, f, l);
    else if (pick < 10) send($urandom_range(0, 1) ? REQ_SOLID : REQ_PASS,
                             $urandom_range(1, 1023), 0);
    else if (pick < 70) send(REQ_SOLID, f, l);
    else send(REQ_PASS, f, l);
  endtask

  initial begin
    int widths [4];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(REQ_PASS, 0, 1023);
    send(REQ_SOLID, 0, 0);
    send(REQ_SOLID, 1023, 1023);
    send(REQ_SOLID, 10, 20);
    send(REQ_SOLID, 30, 40);
    send(REQ_PASS, 5, 50);
    send(REQ_SOLID, 21, 29);
    send(REQ_SOLID, 100, 90);
    send(REQ_NONE, 0, 1023);
    send(REQ_SOLID, 200, 319);
    send(REQ_PASS, 0, 1023);
    send(REQ_SOLID, 41, 199);
    send(REQ_CLEAR, 1023, 0);

    widths = '{1024, 1, 320, 0};
    widths[3] = $urandom_range(2, 1023);
    foreach (widths[p]) begin
      set_view_width(widths[p]);
      if (vw >= 100) fill_list();
      repeat (68) begin
        if (vw >= 100 && $urandom_range(0, 99) == 0) fill_list();
        else random_item();
      end
    end

    drain();
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("occlusion_span_clip_list_top test passed");
    end else begin
      $display("occlusion_span_clip_list_top test failed");
    end
    $finish;
  end

endmodule
